@@ design/wsma_pkg.sv @@
package wsma_pkg;

  localparam int WindowDefault    = 20;
  localparam int AngleBitsDefault = 14;

  localparam int ScaleW   = 24;
  localparam int SpeedW   = 16;
  localparam int FracBits = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(15000);
  localparam logic InvRightReset = 1'b1;
  localparam logic InvLeftReset  = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_SCALE = 2'd0,
    CFG_WRAP_THR    = 2'd1,
    CFG_INV_RIGHT   = 2'd2,
    CFG_INV_LEFT    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic advance;
  } lane_ctrl_t;

endpackage

@@ design/wsma_intf.sv @@
interface wsma_in_if #(
  parameter int ANGLE_BITS = 14
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_right;
  logic [ANGLE_BITS-1:0] angle_left;

  modport source (output valid, output angle_right, output angle_left, input ready);
  modport sink   (input valid, input angle_right, input angle_left, output ready);
endinterface

interface wsma_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_right;
  logic signed [15:0] speed_left;

  modport source (output valid, output speed_right, output speed_left, input ready);
  modport sink   (input valid, input speed_right, input speed_left, output ready);
endinterface

@@ design/wsma_lane.sv @@
module wsma_lane
  import wsma_pkg::*;
#(
  parameter int WINDOW     = WindowDefault,
  parameter int ANGLE_BITS = AngleBitsDefault,
  localparam int DeltaW    = ANGLE_BITS + 1,
  localparam int SumW      = DeltaW + $clog2(WINDOW),
  localparam int ProdW     = SumW + ScaleW + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic [ANGLE_BITS-1:0]   angle_i,
  input  logic [ANGLE_BITS-1:0]   thr_i,
  input  logic                    invert_i,
  input  logic [ScaleW-1:0]       scale_i,
  output logic signed [ProdW-1:0] prod_o
);

  localparam logic signed [DeltaW:0] Turn = {2'b01, {ANGLE_BITS{1'b0}}};

  logic [ANGLE_BITS-1:0]    last_q;
  logic signed [DeltaW:0]   diff, thr_s, wrapped;
  logic signed [DeltaW-1:0] delta;
  logic signed [DeltaW-1:0] hist_q [WINDOW];
  logic signed [SumW-1:0]   sum_q, sum_d;
  logic signed [ProdW-1:0]  prod_q;

  always_comb begin
    diff  = $signed({2'b00, angle_i}) - $signed({2'b00, last_q});
    thr_s = $signed({2'b00, thr_i});
    if (diff < -thr_s) begin
      wrapped = diff + Turn;
    end else if (diff > thr_s) begin
      wrapped = diff - Turn;
    end else begin
      wrapped = diff;
    end
    delta = invert_i ? -wrapped[DeltaW-1:0] : wrapped[DeltaW-1:0];
    sum_d = sum_q + SumW'(delta) - SumW'(hist_q[WINDOW-1]);
  end

  // Delay line: newest delta at tap 0, oldest at the last tap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      sum_q  <= '0;
      for (int i = 0; i < WINDOW; i++) hist_q[i] <= '0;
    end else if (ctrl_i.accept) begin
      last_q    <= angle_i;
      sum_q     <= sum_d;
      hist_q[0] <= delta;
      for (int i = 1; i < WINDOW; i++) hist_q[i] <= hist_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      prod_q <= ProdW'(sum_q) * ProdW'($signed({1'b0, scale_i}));
    end
  end

  assign prod_o = prod_q;

endmodule

@@ design/wsma_merge.sv @@
module wsma_merge
  import wsma_pkg::*;
#(
  parameter int ProdW = 45
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [ProdW-1:0]  prod_right_i,
  input  logic signed [ProdW-1:0]  prod_left_i,
  output lane_ctrl_t               ctrl_o,
  output logic                     out_valid_o,
  output logic signed [SpeedW-1:0] speed_right_o,
  output logic signed [SpeedW-1:0] speed_left_o
);

  localparam int ShW = ProdW - FracBits;

  logic v1_q, v2_q, out_valid_q;
  logic signed [SpeedW-1:0] right_q, left_q;
  lane_ctrl_t ctrl;

  function automatic logic signed [SpeedW-1:0] shift_sat(input logic signed [ProdW-1:0] p);
    logic [ShW-1:0] sh;
    logic           all_one, all_zero;
    sh       = p[ProdW-1:FracBits];
    all_one  = &sh[ShW-1:SpeedW-1];
    all_zero = ~|sh[ShW-1:SpeedW-1];
    if (all_one || all_zero) begin
      return sh[SpeedW-1:0];
    end else if (sh[ShW-1]) begin
      return {1'b1, {(SpeedW-1){1'b0}}};
    end else begin
      return {1'b0, {(SpeedW-1){1'b1}}};
    end
  endfunction

  always_comb begin
    ctrl.advance = !out_valid_q || out_ready_i;
    ctrl.accept  = in_valid_i && ctrl.advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (ctrl.advance) begin
      v1_q        <= ctrl.accept;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.advance) begin
      right_q <= shift_sat(prod_right_i);
      left_q  <= shift_sat(prod_left_i);
    end
  end

  assign ctrl_o        = ctrl;
  assign out_valid_o   = out_valid_q;
  assign speed_right_o = right_q;
  assign speed_left_o  = left_q;

endmodule

@@ design/wheel_speed_moving_average.sv @@
// Wheel speed moving average. Each sample item carries one absolute angle per
// wheel encoder (2**ANGLE_BITS counts per turn). Per wheel, a lane forms the
// delta against the previous angle (the first previous angle after reset is
// zero), corrects one full turn when the delta passes +-wrap_threshold,
// optionally negates it, and keeps a running sum over the last WINDOW deltas
// held in a shift line that starts at zero. The sum times the unsigned Q8.16
// speed_scale, floored by 2**16 and saturated to 16-bit signed, is the speed
// in mm/s. Each item yields exactly one result item holding both speeds.
// Throughput is one item per clock while no finished result waits. The path
// holds three registers: the running-sum register (loaded at the accepting
// edge), the product register and the output register; result valid follows
// the item through them. The product and output registers advance whenever
// the output register is empty or being taken; the sum register then loads
// only if an item is accepted. Ready drops only while a finished result waits.
// Registers (cfg_idx_i): 0 speed_scale, 1 wrap_threshold, 2 invert_right,
// 3 invert_left; write them only while the block is idle.
module wheel_speed_moving_average
  import wsma_pkg::*;
#(
  parameter int WINDOW     = WindowDefault,
  parameter int ANGLE_BITS = AngleBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  wsma_in_if.sink             sample_i,
  wsma_out_if.source          result_o
);

  localparam int ProdW = ANGLE_BITS + 1 + $clog2(WINDOW) + ScaleW + 1;
  // Default threshold: five sixths of a turn
  localparam logic [ANGLE_BITS-1:0] ThrReset = ANGLE_BITS'(((1 << ANGLE_BITS) * 5) / 6);

  logic [ScaleW-1:0]      scale_q;
  logic [ANGLE_BITS-1:0]  thr_q;
  logic                   inv_right_q, inv_left_q;
  lane_ctrl_t             ctrl;
  logic signed [ProdW-1:0] prod_right, prod_left;

  // Hold configuration; ignore nothing, every index is a register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= ScaleReset;
      thr_q       <= ThrReset;
      inv_right_q <= InvRightReset;
      inv_left_q  <= InvLeftReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPEED_SCALE: scale_q     <= cfg_data_i[ScaleW-1:0];
        CFG_WRAP_THR:    thr_q       <= cfg_data_i[ANGLE_BITS-1:0];
        CFG_INV_RIGHT:   inv_right_q <= cfg_data_i[0];
        CFG_INV_LEFT:    inv_left_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // One lane per wheel, sharing the control from the merge stage
  wsma_lane #(.WINDOW(WINDOW), .ANGLE_BITS(ANGLE_BITS)) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .angle_i  (sample_i.angle_right),
    .thr_i    (thr_q),
    .invert_i (inv_right_q),
    .scale_i  (scale_q),
    .prod_o   (prod_right)
  );

  wsma_lane #(.WINDOW(WINDOW), .ANGLE_BITS(ANGLE_BITS)) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .angle_i  (sample_i.angle_left),
    .thr_i    (thr_q),
    .invert_i (inv_left_q),
    .scale_i  (scale_q),
    .prod_o   (prod_left)
  );

  // Shift, saturate and pack both speeds into the output register
  wsma_merge #(.ProdW(ProdW)) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (sample_i.valid),
    .out_ready_i   (result_o.ready),
    .prod_right_i  (prod_right),
    .prod_left_i   (prod_left),
    .ctrl_o        (ctrl),
    .out_valid_o   (result_o.valid),
    .speed_right_o (result_o.speed_right),
    .speed_left_o  (result_o.speed_left)
  );

  assign sample_i.ready = ctrl.advance;

endmodule

@@ design/wsma_checker.sv @@
module wsma_checker
  import wsma_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [SpeedW-1:0] speed_right_i,
  input logic [SpeedW-1:0] speed_left_i
);

  logic [2:0] cnt_q;

  // Items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_valid_i && in_ready_i) - 3'(out_valid_i && out_ready_i);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(speed_right_i)
                                    && $stable(speed_left_i))
    else $error("stalled result changed");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("more than three items in flight");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("result without an accepted item");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule

bind wheel_speed_moving_average wsma_checker u_wsma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (sample_i.valid),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .speed_right_i (result_o.speed_right),
  .speed_left_i  (result_o.speed_left)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

// Check the wheel speed moving average against a cycle-free model of the
// same arithmetic. Every accepted sample item is run through the model at the
// accepting edge, and each speed result the block hands out is compared with
// the oldest prediction still pending.
module tb_top;
  import wsma_pkg::*;

  localparam int Turn       = 1 << AngleBitsDefault;
  localparam int PipeDepth  = 3;     // sum, product and output registers
  localparam int QuietLimit = 4000;  // edges with no handshake before giving up
  localparam int SegItems   = 175;   // random items per configuration segment

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_right;
    logic signed [SpeedW-1:0] speed_left;
  } speed_pair_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  wsma_in_if #(.ANGLE_BITS(AngleBitsDefault)) sample_if ();
  wsma_out_if                                  result_if ();

  wheel_speed_moving_average dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idle rates in percent, changed by the test flow between phases.
  int unsigned src_idle_pct   = 17;
  int unsigned sink_stall_pct = 63;
  int          fail_count     = 0;
  int          quiet_cycles   = 0;

  // Last angles handed to the block, used to build smooth motion.
  logic [AngleBitsDefault-1:0] angle_now_right = '0;
  logic [AngleBitsDefault-1:0] angle_now_left  = '0;

  // Model copy of the configuration registers, at their reset values.
  logic [ScaleW-1:0]           speed_scale_q  = ScaleReset;
  logic [AngleBitsDefault-1:0] wrap_thr_q     = 14'd13653;
  logic                        invert_right_q = InvRightReset;
  logic                        invert_left_q  = InvLeftReset;

  // Model copy of the per-wheel state: previous angles, delta history, sums.
  logic [AngleBitsDefault-1:0] prev_angle_right = '0;
  logic [AngleBitsDefault-1:0] prev_angle_left  = '0;
  logic signed [14:0]          hist_right [WindowDefault] = '{default: '0};
  logic signed [14:0]          hist_left  [WindowDefault] = '{default: '0};
  logic signed [19:0]          sum_right = '0;
  logic signed [19:0]          sum_left  = '0;
  int                          slot      = 0;

  speed_pair_t pending_speeds [$];

  // Receiver side: stall at the current rate; hold ready low until the first edge.
  logic result_ready = 1'b0;
  assign result_if.ready = result_ready;

  always @(posedge clk_i) begin
    result_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Delta against the previous angle, one turn folded back when it passes
  // the threshold in either direction; a delta exactly on it is kept.
  function automatic logic signed [14:0] wheel_delta(input logic [AngleBitsDefault-1:0] now,
                                                     input logic [AngleBitsDefault-1:0] prev,
                                                     input logic invert);
    int d;
    d = int'(now) - int'(prev);
    if (d < -int'(wrap_thr_q)) begin
      d += Turn;
    end else if (d > int'(wrap_thr_q)) begin
      d -= Turn;
    end
    if (invert) begin
      d = -d;
    end
    return 15'(d);
  endfunction

  // Sum times the Q8.16 gain; the arithmetic shift floors negative products.
  function automatic logic signed [SpeedW-1:0] scaled_speed(input logic signed [19:0] sum);
    longint prod;
    prod = longint'(sum) * longint'(speed_scale_q);
    prod = prod >>> FracBits;
    if (prod > 32767) begin
      return 16'sh7FFF;
    end
    if (prod < -32768) begin
      return 16'sh8000;
    end
    return SpeedW'(prod);
  endfunction

  // Advance both wheels by one sample and return the speeds that follow.
  function automatic speed_pair_t average_speeds(input logic [AngleBitsDefault-1:0] ang_r,
                                                 input logic [AngleBitsDefault-1:0] ang_l);
    speed_pair_t        res;
    logic signed [14:0] d_r;
    logic signed [14:0] d_l;
    d_r = wheel_delta(ang_r, prev_angle_right, invert_right_q);
    d_l = wheel_delta(ang_l, prev_angle_left, invert_left_q);
    prev_angle_right = ang_r;
    prev_angle_left  = ang_l;
    // Running sum: add the new delta, drop the one leaving the window.
    sum_right = sum_right + d_r - hist_right[slot];
    sum_left  = sum_left + d_l - hist_left[slot];
    hist_right[slot] = d_r;
    hist_left[slot]  = d_l;
    slot = (slot + 1) % WindowDefault;
    res.speed_right = scaled_speed(sum_right);
    res.speed_left  = scaled_speed(sum_left);
    return res;
  endfunction

  // Predict at the accepting edge, so the model sees items in handshake order.
  always @(posedge clk_i) begin
    if (rst_ni && sample_if.valid && sample_if.ready) begin
      pending_speeds.push_back(average_speeds(sample_if.angle_right, sample_if.angle_left));
    end
  end

  // Compare each taken result with the oldest pending prediction.
  always @(posedge clk_i) begin
    speed_pair_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_speeds.size() == 0) begin
        $display("%0t: result with none pending: speed_right %0d speed_left %0d",
                 $time, result_if.speed_right, result_if.speed_left);
        fail_count++;
      end else begin
        want = pending_speeds.pop_front();
        if (result_if.speed_right !== want.speed_right) begin
          $display("%0t: speed_right expected %0d, got %0d",
                   $time, want.speed_right, result_if.speed_right);
          fail_count++;
        end
        if (result_if.speed_left !== want.speed_left) begin
          $display("%0t: speed_left expected %0d, got %0d",
                   $time, want.speed_left, result_if.speed_left);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample item, after a random gap, and hold it until taken.
  // Leave valid high on return so back-to-back items stream without a bubble.
  task automatic send_sample(input logic [AngleBitsDefault-1:0] angle_r,
                             input logic [AngleBitsDefault-1:0] angle_l);
    if ($urandom_range(99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    sample_if.valid       <= 1'b1;
    sample_if.angle_right <= angle_r;
    sample_if.angle_left  <= angle_l;
    do @(posedge clk_i); while (!sample_if.ready);
    angle_now_right = angle_r;
    angle_now_left  = angle_l;
  endtask

  // Drop valid and wait until every predicted result has been taken, then
  // let the pipeline run empty before anything touches the registers.
  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_speeds.size() != 0);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // Write all four registers, one per edge; the block masks each to its width.
  task automatic set_config(input logic [CfgDataW-1:0] scale, input logic [CfgDataW-1:0] thr,
                            input logic [CfgDataW-1:0] inv_r, input logic [CfgDataW-1:0] inv_l);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SPEED_SCALE;
    cfg_data_i <= scale;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WRAP_THR;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INV_RIGHT;
    cfg_data_i <= inv_r;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INV_LEFT;
    cfg_data_i <= inv_l;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    speed_scale_q  = scale[ScaleW-1:0];
    wrap_thr_q     = thr[AngleBitsDefault-1:0];
    invert_right_q = inv_r[0];
    invert_left_q  = inv_l[0];
  endtask

  // Reset configuration: the previous angle starts at zero, so the first
  // delta is the angle itself, folded like any other.
  task automatic test_first_samples();
    send_sample(14'd16383, 14'd13653);  // right folds to -1, left sits on the threshold
    send_sample(14'd0, 14'd0);          // right -16383 folds, left -13653 is kept
    send_sample(14'd13654, 14'd16383);  // right one past the threshold, left +16383 folds
    send_sample(14'd0, 14'd2730);       // right -13654 folds, left -13653 kept
    send_sample(14'd8192, 14'd10922);
    wait_idle();
  endtask

  // Threshold extremes, including junk above the register widths.
  task automatic test_wrap_threshold();
    set_config(24'd15000, 24'd0, 24'd1, 24'd0);
    send_sample(14'd8193, 14'd10923);   // +1 folds to -16383 on a zero threshold
    send_sample(14'd8192, 14'd10922);   // -1 folds to +16383
    send_sample(14'd8192, 14'd10922);   // zero delta stays zero
    wait_idle();
    set_config(24'd15000, 24'hFFFFFF, 24'hFFFFFE, 24'h000003);
    send_sample(14'd16383, 14'd0);
    send_sample(14'd0, 14'd16383);      // full-scale deltas never fold at 16383
    send_sample(14'd16383, 14'd0);
    wait_idle();
    set_config(24'd15000, 24'd1, 24'd1, 24'd1);
    send_sample(14'd16382, 14'd1);      // +-1 kept on a threshold of one
    send_sample(14'd0, 14'd16383);      // +-2 fold
    wait_idle();
  endtask

  // Gain extremes: saturate high at full gain, then zero gain, unity gain
  // and a gain of one LSB, which floors the positive sums here to zero.
  task automatic test_gain_and_saturation();
    set_config(24'hFFFFFF, 24'd13653, 24'd0, 24'd1);
    send_sample(14'd4000, 14'd4000);
    send_sample(14'd8000, 14'd8000);
    wait_idle();
    set_config(24'd0, 24'd13653, 24'd1, 24'd0);
    send_sample(14'd12000, 14'd12000);
    wait_idle();
    set_config(24'd65536, 24'd13653, 24'd0, 24'd0);
    send_sample(14'd11000, 14'd13000);
    send_sample(14'd10990, 14'd13010);
    wait_idle();
    set_config(24'd1, 24'd13653, 24'd0, 24'd1);
    send_sample(14'd10000, 14'd13000);
    send_sample(14'd9999, 14'd13001);
    wait_idle();
  endtask

  // Mostly smooth motion with a fresh random velocity every so often, and
  // about one item in ten a random jump that breaks the motion.
  task automatic run_random_traffic(input int count);
    int vel_r;
    int vel_l;
    int span;
    logic [AngleBitsDefault-1:0] ar;
    logic [AngleBitsDefault-1:0] al;
    vel_r = 0;
    vel_l = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 32 == 0) begin
        case ($urandom_range(3))
          0:       span = 50;
          1:       span = 600;
          2:       span = 4000;
          default: span = Turn - 1;
        endcase
        vel_r = int'($urandom_range(2 * span)) - span;
        vel_l = int'($urandom_range(2 * span)) - span;
      end
      if ($urandom_range(9) == 0) begin
        ar = AngleBitsDefault'($urandom);
        al = AngleBitsDefault'($urandom);
      end else begin
        ar = AngleBitsDefault'(int'(angle_now_right) + vel_r);
        al = AngleBitsDefault'(int'(angle_now_left) + vel_l);
      end
      send_sample(ar, al);
    end
  endtask

  // Three idle patterns, two random configurations each.
  task automatic test_random_traffic();
    int unsigned src_rates  [3] = '{17, 63, 0};
    int unsigned sink_rates [3] = '{63, 17, 0};
    logic [CfgDataW-1:0] scale;
    logic [CfgDataW-1:0] thr;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct   = src_rates[ph];
      sink_stall_pct = sink_rates[ph];
      for (int seg = 0; seg < 2; seg++) begin
        case ($urandom_range(5))
          0:       scale = 24'hFFFFFF;
          1:       scale = 24'd15000;
          2:       scale = 24'($urandom_range(200000));
          3:       scale = 24'($urandom_range(8));
          default: scale = 24'($urandom);
        endcase
        case ($urandom_range(4))
          0:       thr = 24'd0;
          1:       thr = 24'd16383;
          2:       thr = 24'd13653;
          3:       thr = 24'($urandom_range(600));
          default: thr = 24'($urandom);
        endcase
        set_config(scale, thr, 24'($urandom_range(1)), 24'($urandom_range(1)));
        run_random_traffic(SegItems);
        wait_idle();
      end
    end
  endtask

  initial begin
    // Hold every input at a known value from time zero.
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_SPEED_SCALE;
    cfg_data_i            <= '0;
    sample_if.valid       <= 1'b0;
    sample_if.angle_right <= '0;
    sample_if.angle_left  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_samples();
    test_wrap_threshold();
    test_gain_and_saturation();
    test_random_traffic();

    if (fail_count == 0 && pending_speeds.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/wsma_pkg.sv
design/wsma_intf.sv
design/wsma_lane.sv
design/wsma_merge.sv
design/wheel_speed_moving_average.sv
design/wsma_checker.sv
tb/sv/tb_top.sv
